// ----- rtl/core/mips_itype_execute_unit_macros.svh -----
`ifndef MIPS_ITYPE_EXECUTE_UNIT_MACROS_SVH
`define MIPS_ITYPE_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define MIE_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define MIE_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mie_pkg.sv -----
package mie_pkg;

    // Byte lanes of the data memory
    localparam int LANES = 4;

    // Operation selector
    typedef enum logic [4:0] {
        OP_ADDI  = 5'd0,
        OP_ADDIU = 5'd1,
        OP_ANDI  = 5'd2,
        OP_ORI   = 5'd3,
        OP_XORI  = 5'd4,
        OP_SLTI  = 5'd5,
        OP_SLTIU = 5'd6,
        OP_BEQ   = 5'd7,
        OP_BNE   = 5'd8,
        OP_LB    = 5'd9,
        OP_LBU   = 5'd10,
        OP_LH    = 5'd11,
        OP_LHU   = 5'd12,
        OP_LW    = 5'd13,
        OP_LUI   = 5'd14,
        OP_SB    = 5'd15,
        OP_SH    = 5'd16,
        OP_SW    = 5'd17
    } op_t;

    // One instruction in flight behind the operand stage
    typedef struct packed {
        op_t         op;
        logic        wr;
        logic        ld;
        logic        mw;
        logic        taken;
        logic [4:0]  rt;
        logic [31:0] val;
        logic [31:0] addr;
        logic [31:0] sdata;
        logic [31:0] target;
    } pipe_t;

endpackage

// ----- rtl/core/mips_itype_execute_unit.sv -----
// I-type execute unit with a 32 x 32 register file and a byte-addressed,
// little-endian data memory of MEM_BYTES bytes (a multiple of four).
// Input channel s_*: one instruction per beat (mode, word, pc).
// Result channel m_*: one result per instruction, in order.
// Pipeline: operand read and execute, two modulo steps, memory access,
// load align / writeback, output register.
// Throughput is one instruction per cycle when nothing stalls. ALU results
// are forwarded from every stage; an instruction that reads a register
// loaded by one of the three instructions ahead of it waits until the load
// data returns from the memory stage.
// Reset: the register file reads zero at once (valid bits). The data
// memory is zeroed by a sweep over its MEM_BYTES/4 rows, one row of four
// bytes a cycle, during which s_ready stays low.
// Stall: while m_valid is high and m_ready low every stage past the operand stage holds;
// s_ready stays high only while the operand stage is free.
`include "mips_itype_execute_unit_macros.svh"

module mips_itype_execute_unit
    import mie_pkg::*;
#(
    parameter int MEM_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_mode,
    input  logic [31:0] s_instr_word,
    input  logic [31:0] s_cur_pc,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_reg_written,
    output logic [4:0]  m_dest_index,
    output logic [31:0] m_dest_value,
    output logic        m_mem_written,
    output logic        m_branch_taken,
    output logic [31:0] m_branch_target
);

    localparam int              ROWS       = MEM_BYTES / LANES;
    localparam int              ROW_W      = $clog2(ROWS);
    localparam logic [63:0]     RECIP_WIDE = (64'd1 << 32) / 64'(ROWS);
    localparam logic [31:0]     RECIP      = RECIP_WIDE[31:0];
    localparam logic [29:0]     ROWS_Q     = 30'(ROWS);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sext8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    // Newest pending write to idx wins over older ones and the file
    function automatic logic [31:0] pick(
        input logic [4:0]  idx,
        input logic [31:0] base,
        input logic        cv,
        input pipe_t       cp,
        input logic        dv,
        input pipe_t       dp,
        input logic        ev,
        input pipe_t       ep,
        input logic        fv,
        input pipe_t       fp,
        input logic [31:0] fval
    );
        logic [31:0] v;
        v = base;
        if (fv && fp.wr && fp.rt == idx) v = fval;
        if (ev && ep.wr && ep.rt == idx) v = ep.val;
        if (dv && dp.wr && dp.rt == idx) v = dp.val;
        if (cv && cp.wr && cp.rt == idx) v = cp.val;
        return v;
    endfunction

    function automatic logic load_hit(
        input logic       v,
        input pipe_t      p,
        input logic [4:0] rs,
        input logic [4:0] rt,
        input logic       need_b
    );
        return v && p.ld && (p.rt == rs || (need_b && p.rt == rt));
    endfunction

    // Flow control
    logic adv;
    logic hazard;
    logic b_go;

    // Clearing sweep
    logic             clr_active_reg, clr_active_next;
    logic [ROW_W-1:0] clr_row_reg, clr_row_next;

    // Operand stage
    logic        b_valid_reg, b_valid_next;
    logic [4:0]  b_mode_reg;
    logic [25:0] b_iw_reg;
    logic [31:0] b_pc_reg;
    op_t         b_op;
    logic [4:0]  b_rs, b_rt;
    logic [15:0] b_imm;
    logic [31:0] b_simm, b_sum, opa, opb;
    logic        b_need_b;
    pipe_t       b_res;

    // Later stages
    logic  c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg, o_valid_reg;
    pipe_t c_reg, d_reg, e_reg, f_reg;
    logic [61:0] c_prod;
    logic [29:0] d_quot_reg, d_qm, e_qm_reg, e_rem;
    logic [ROW_W-1:0] e_row0, e_row1;
    logic [1:0]  e_off, e_size;
    logic [1:0]  f_off;
    logic [31:0] f_word, f_val;

    // Data memory lanes
    logic [LANES-1:0]            lane_we;
    logic [LANES-1:0][ROW_W-1:0] lane_row;
    logic [LANES-1:0][7:0]       lane_wdata, lane_rdata;

    // Register file
    logic [31:0] rf_mem [32];
    logic [31:0] rf_vld_reg;
    logic [31:0] rf_a_reg, rf_b_reg;
    logic [4:0]  rf_ra, rf_rb;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;

    // Output register
    logic        o_wr_reg, o_mw_reg, o_taken_reg;
    logic [4:0]  o_dest_reg;
    logic [31:0] o_value_reg, o_target_reg;

    // Advance everything past the operand stage unless a result is stuck
    assign adv     = !o_valid_reg || m_ready;
    assign b_go    = adv && !hazard;
    assign s_ready = !clr_active_reg && (!b_valid_reg || b_go);

    // Step the clearing sweep
    always_comb begin
        clr_active_next = clr_active_reg;
        clr_row_next    = clr_row_reg;
        if (clr_active_reg) begin
            clr_row_next = clr_row_reg + ROW_W'(1);
            if (clr_row_reg == ROW_LAST) clr_active_next = 1'b0;
        end
    end

    assign b_valid_next = s_ready ? s_valid : b_valid_reg;

    // Decode operand stage
    assign b_op   = op_t'(b_mode_reg);
    assign b_rs   = b_iw_reg[25:21];
    assign b_rt   = b_iw_reg[20:16];
    assign b_imm  = b_iw_reg[15:0];
    assign b_simm = sext16(b_imm);

    always_comb begin
        case (b_op)
            OP_BEQ, OP_BNE, OP_SB, OP_SH, OP_SW: b_need_b = 1'b1;
            default:                             b_need_b = 1'b0;
        endcase
    end

    // Hold the operand stage while a load ahead still owes a source
    assign hazard = b_valid_reg &&
                    (load_hit(c_valid_reg, c_reg, b_rs, b_rt, b_need_b) ||
                     load_hit(d_valid_reg, d_reg, b_rs, b_rt, b_need_b) ||
                     load_hit(e_valid_reg, e_reg, b_rs, b_rt, b_need_b));

    assign opa = pick(b_rs, rf_a_reg, c_valid_reg, c_reg, d_valid_reg, d_reg,
                      e_valid_reg, e_reg, f_valid_reg, f_reg, f_val);
    assign opb = pick(b_rt, rf_b_reg, c_valid_reg, c_reg, d_valid_reg, d_reg,
                      e_valid_reg, e_reg, f_valid_reg, f_reg, f_val);
    assign b_sum = opa + b_simm;

    // Execute
    always_comb begin
        b_res       = '0;
        b_res.op    = b_op;
        b_res.rt    = b_rt;
        b_res.addr  = b_sum;
        b_res.sdata = opb;
        case (b_op)
            OP_ADDI, OP_ADDIU: begin
                b_res.wr  = 1'b1;
                b_res.val = b_sum;
            end
            OP_ANDI: begin
                b_res.wr  = 1'b1;
                b_res.val = opa & {16'h0000, b_imm};
            end
            OP_ORI: begin
                b_res.wr  = 1'b1;
                b_res.val = opa | {16'h0000, b_imm};
            end
            OP_XORI: begin
                b_res.wr  = 1'b1;
                b_res.val = opa ^ {16'h0000, b_imm};
            end
            OP_SLTI: begin
                b_res.wr  = 1'b1;
                b_res.val = {31'd0, $signed(opa) < $signed(b_simm)};
            end
            OP_SLTIU: begin
                b_res.wr  = 1'b1;
                b_res.val = {31'd0, opa < b_simm};
            end
            OP_BEQ: begin
                b_res.taken  = (opa == opb);
                b_res.target = b_pc_reg + 32'd4 + {b_simm[29:0], 2'b00};
            end
            OP_BNE: begin
                b_res.taken  = (opa != opb);
                b_res.target = b_pc_reg + 32'd4 + {b_simm[29:0], 2'b00};
            end
            OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW: begin
                b_res.wr = 1'b1;
                b_res.ld = 1'b1;
            end
            OP_LUI: begin
                b_res.wr  = 1'b1;
                b_res.val = {b_imm, 16'h0000};
            end
            OP_SB, OP_SH, OP_SW: begin
                b_res.mw = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Row quotient estimate from the reciprocal
    assign c_prod = 62'(c_reg.addr[31:2]) * 62'(RECIP);
    assign d_qm   = d_quot_reg * ROWS_Q;

    // Remainder with one correction, then the row after it
    assign e_rem  = e_reg.addr[31:2] - e_qm_reg;
    assign e_row0 = (e_rem >= ROWS_Q) ? ROW_W'(e_rem - ROWS_Q) : ROW_W'(e_rem);
    assign e_row1 = (e_row0 == ROW_LAST) ? '0 : e_row0 + ROW_W'(1);
    assign e_off  = e_reg.addr[1:0];

    always_comb begin
        case (e_reg.op)
            OP_SB:   e_size = 2'd0;
            OP_SH:   e_size = 2'd1;
            default: e_size = 2'd3;
        endcase
    end

    // One byte-wide memory per lane; a beat touches each lane at most once
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [1:0] bsel;
        logic [7:0] mem [ROWS];
        logic [7:0] rd_reg;

        assign bsel          = 2'(l) - e_off;
        assign lane_row[l]   = (2'(l) < e_off) ? e_row1 : e_row0;
        assign lane_we[l]    = adv && e_valid_reg && e_reg.mw && (bsel <= e_size);
        assign lane_wdata[l] = 8'(e_reg.sdata >> {bsel, 3'b000});

        always_ff @(posedge aclk) begin
            if (clr_active_reg) begin
                mem[clr_row_reg] <= '0;
            end else if (lane_we[l]) begin
                mem[lane_row[l]] <= lane_wdata[l];
            end
            if (adv) begin
                rd_reg <= mem[lane_row[l]];
            end
        end

        assign lane_rdata[l] = rd_reg;
    end

    // Align load data
    assign f_off = f_reg.addr[1:0];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            f_word[8*i +: 8] = lane_rdata[2'(f_off + 2'(i))];
        end
    end

    always_comb begin
        case (f_reg.op)
            OP_LB:   f_val = sext8(f_word[7:0]);
            OP_LBU:  f_val = {24'd0, f_word[7:0]};
            OP_LH:   f_val = sext16(f_word[15:0]);
            OP_LHU:  f_val = {16'd0, f_word[15:0]};
            OP_LW:   f_val = f_word;
            default: f_val = f_reg.val;
        endcase
    end

    // Register file: write back at the align stage, bypass into the read
    assign rf_we    = adv && f_valid_reg && f_reg.wr;
    assign rf_waddr = f_reg.rt;
    assign rf_wdata = f_val;
    assign rf_ra    = s_ready ? s_instr_word[25:21] : b_rs;
    assign rf_rb    = s_ready ? s_instr_word[20:16] : b_rt;

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        if (rf_we && rf_waddr == rf_ra) begin
            rf_a_reg <= rf_wdata;
        end else if (rf_vld_reg[rf_ra]) begin
            rf_a_reg <= rf_mem[rf_ra];
        end else begin
            rf_a_reg <= '0;
        end
        if (rf_we && rf_waddr == rf_rb) begin
            rf_b_reg <= rf_wdata;
        end else if (rf_vld_reg[rf_rb]) begin
            rf_b_reg <= rf_mem[rf_rb];
        end else begin
            rf_b_reg <= '0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
            rf_vld_reg     <= '0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            e_valid_reg    <= 1'b0;
            f_valid_reg    <= 1'b0;
            o_valid_reg    <= 1'b0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_row_reg    <= clr_row_next;
            b_valid_reg    <= b_valid_next;
            if (rf_we) begin
                rf_vld_reg[rf_waddr] <= 1'b1;
            end
            if (adv) begin
                c_valid_reg <= b_valid_reg && !hazard;
                d_valid_reg <= c_valid_reg;
                e_valid_reg <= d_valid_reg;
                f_valid_reg <= e_valid_reg;
                o_valid_reg <= f_valid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            b_mode_reg <= s_mode;
            b_iw_reg   <= s_instr_word[25:0];
            b_pc_reg   <= s_cur_pc;
        end
        if (adv) begin
            c_reg        <= b_res;
            d_reg        <= c_reg;
            d_quot_reg   <= c_prod[61:32];
            e_reg        <= d_reg;
            e_qm_reg     <= d_qm;
            f_reg        <= e_reg;
            o_wr_reg     <= f_reg.wr;
            o_dest_reg   <= f_reg.wr ? f_reg.rt : 5'd0;
            o_value_reg  <= f_reg.wr ? f_val : 32'd0;
            o_mw_reg     <= f_reg.mw;
            o_taken_reg  <= f_reg.taken;
            o_target_reg <= f_reg.target;
        end
    end

    assign m_valid         = o_valid_reg;
    assign m_reg_written   = o_wr_reg;
    assign m_dest_index    = o_dest_reg;
    assign m_dest_value    = o_value_reg;
    assign m_mem_written   = o_mw_reg;
    assign m_branch_taken  = o_taken_reg;
    assign m_branch_target = o_target_reg;

    // Pipeline stays empty while the data memory is being zeroed
    `MIE_ASSERT_IMP(a_clear_empty, aclk, aresetn, clr_active_reg, !b_valid_reg && !c_valid_reg && !d_valid_reg && !e_valid_reg && !f_valid_reg, "beat in flight during memory clear")
    // A load-use interlock holds the instruction and sends a bubble ahead
    `MIE_ASSERT_NXT(a_interlock_bubble, aclk, aresetn, hazard && adv, b_valid_reg && !c_valid_reg, "interlock did not insert a bubble")
    // Modulo unit always lands inside the memory
    `MIE_ASSERT_IMP(a_row_range, aclk, aresetn, e_valid_reg, e_row0 <= ROW_LAST, "memory row out of range")

endmodule

// ----- tb/mips_itype_execute_unit_tb.sv -----
module mips_itype_execute_unit_tb
    import mie_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_BYTES = 4096;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    // One retired instruction as seen on the result channel
    typedef struct packed {
        logic        reg_written;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        mem_written;
        logic        branch_taken;
        logic [31:0] branch_target;
    } exec_res_t;

    // One row of the directed instruction table
    typedef struct {
        logic [4:0]  mode;
        logic [31:0] iw;
        logic [31:0] pc;
        bit          typed;
        exec_res_t   res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [4:0]  s_mode = '0;
    logic [31:0] s_instr_word = '0;
    logic [31:0] s_cur_pc = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_reg_written;
    logic [4:0]  m_dest_index;
    logic [31:0] m_dest_value;
    logic        m_mem_written;
    logic        m_branch_taken;
    logic [31:0] m_branch_target;

    // Shadow architectural state
    logic [31:0] gpr_shadow [32];
    logic [7:0]  dmem_shadow [MEM_BYTES];

    exec_res_t   retire_q [$];
    dir_row_t    dir_tab [$];

    int          n_err = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_taken = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;

    mips_itype_execute_unit #(
        .MEM_BYTES(MEM_BYTES)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_instr_word   (s_instr_word),
        .s_cur_pc       (s_cur_pc),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reg_written  (m_reg_written),
        .m_dest_index   (m_dest_index),
        .m_dest_value   (m_dest_value),
        .m_mem_written  (m_mem_written),
        .m_branch_taken (m_branch_taken),
        .m_branch_target(m_branch_target)
    );

    always #5 aclk = ~aclk;

    // Backpressure on the result channel
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic logic [31:0] mk_iw(logic [4:0] rs, logic [4:0] rt, logic [15:0] imm);
        return {6'b000000, rs, rt, imm};
    endfunction

    function automatic logic [MEM_AW-1:0] dmem_index(logic [31:0] addr, int i);
        logic [31:0] sum;
        sum = addr + 32'(i);
        return MEM_AW'(sum % MEM_BYTES);
    endfunction

    // Execute one instruction on the shadow state and return its result
    function automatic exec_res_t exec_predict(logic [4:0] mode, logic [31:0] iw,
                                               logic [31:0] pc);
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [31:0] simm;
        logic [31:0] zimm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] addr;
        logic [31:0] ld;
        logic [31:0] val;
        logic        wr;
        int          nst;
        exec_res_t   r;
        rs   = iw[25:21];
        rt   = iw[20:16];
        simm = {{16{iw[15]}}, iw[15:0]};
        zimm = {16'h0000, iw[15:0]};
        a    = gpr_shadow[rs];
        b    = gpr_shadow[rt];
        addr = a + simm;
        ld   = '0;
        for (int i = 0; i < 4; i++) ld[8*i +: 8] = dmem_shadow[dmem_index(addr, i)];
        r    = '0;
        wr   = 1'b0;
        val  = '0;
        nst  = 0;
        case (mode)
            OP_ADDI, OP_ADDIU: begin wr = 1'b1; val = a + simm; end
            OP_ANDI:  begin wr = 1'b1; val = a & zimm; end
            OP_ORI:   begin wr = 1'b1; val = a | zimm; end
            OP_XORI:  begin wr = 1'b1; val = a ^ zimm; end
            OP_SLTI:  begin wr = 1'b1; val = {31'b0, $signed(a) < $signed(simm)}; end
            OP_SLTIU: begin wr = 1'b1; val = {31'b0, a < simm}; end
            OP_BEQ, OP_BNE: begin
                r.branch_target = pc + 32'd4 + (simm << 2);
                r.branch_taken  = (mode == OP_BEQ) ? (a == b) : (a != b);
            end
            OP_LB:    begin wr = 1'b1; val = {{24{ld[7]}}, ld[7:0]}; end
            OP_LBU:   begin wr = 1'b1; val = {24'h0, ld[7:0]}; end
            OP_LH:    begin wr = 1'b1; val = {{16{ld[15]}}, ld[15:0]}; end
            OP_LHU:   begin wr = 1'b1; val = {16'h0, ld[15:0]}; end
            OP_LW:    begin wr = 1'b1; val = ld; end
            OP_LUI:   begin wr = 1'b1; val = {iw[15:0], 16'h0000}; end
            OP_SB:    nst = 1;
            OP_SH:    nst = 2;
            OP_SW:    nst = 4;
            default:  ;
        endcase
        // Commit stores and register writes
        for (int i = 0; i < nst; i++) dmem_shadow[dmem_index(addr, i)] = b[8*i +: 8];
        r.mem_written = (nst != 0);
        if (wr) begin
            gpr_shadow[rt] = val;
            r.reg_written  = 1'b1;
            r.dest_index   = rt;
            r.dest_value   = val;
        end
        return r;
    endfunction

    // Offer one beat, wait for acceptance, record the expected result
    task automatic send_beat(logic [4:0] mode, logic [31:0] iw, logic [31:0] pc,
                             bit typed, exec_res_t typed_res);
        int        gap;
        exec_res_t r;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_instr_word <= iw;
        s_cur_pc     <= pc;
        do @(posedge aclk); while (!s_ready);
        r = exec_predict(mode, iw, pc);
        if (r.branch_taken) n_taken++;
        retire_q.push_back(typed ? typed_res : r);
        n_sent++;
    endtask

    // Hold the sender until every beat in flight has come back
    task automatic drain_results();
        if (s_valid) s_valid <= 1'b0;
        while (retire_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(99) < 70) ? 5'($urandom_range(7, 0)) : 5'($urandom_range(31, 0));
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            4, 5:    return 16'($signed($urandom_range(32, 0)) - 16);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic is_store(logic [4:0] m);
        return (m == OP_SB) || (m == OP_SH) || (m == OP_SW);
    endfunction

    function automatic logic is_load(logic [4:0] m);
        return (m >= OP_LB) && (m <= OP_LW);
    endfunction

    // One random instruction, sometimes followed by a dependent one
    task automatic send_random();
        logic [4:0]  mode;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  m2;
        logic [15:0] imm;
        logic [31:0] pc;
        mode = ($urandom_range(99) < 5) ? 5'($urandom_range(31, 18)) : 5'($urandom_range(17, 0));
        rs   = pick_reg();
        rt   = pick_reg();
        imm  = pick_imm();
        if ((mode == OP_BEQ || mode == OP_BNE) && $urandom_range(99) < 40) rt = rs;
        pc   = ($urandom_range(99) < 20) ? 32'hFFFF_FFF0 + 32'($urandom_range(15)) : $urandom;
        send_beat(mode, {6'($urandom), rs, rt, imm}, pc, 1'b0, '0);
        if (is_store(mode) && $urandom_range(99) < 50) begin
            // read back the stored location right away
            m2 = 5'($urandom_range(OP_LW, OP_LB));
            send_beat(m2, {6'($urandom), rs, pick_reg(), imm}, $urandom, 1'b0, '0);
        end else if (is_load(mode) && $urandom_range(99) < 50) begin
            // consume the loaded register in the next instruction
            m2 = 5'($urandom_range(OP_SW, OP_ADDI));
            send_beat(m2, {6'($urandom), rt, pick_reg(), pick_imm()}, $urandom, 1'b0, '0);
        end
    endtask

    function automatic void add_row(logic [4:0] mode, logic [4:0] rs, logic [4:0] rt,
                                    logic [15:0] imm, logic [31:0] pc, bit typed,
                                    exec_res_t res);
        dir_row_t row;
        row.mode  = mode;
        row.iw    = mk_iw(rs, rt, imm);
        row.pc    = pc;
        row.typed = typed;
        row.res   = res;
        dir_tab.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_err++;
        end
    endfunction

    // Compare each retired beat with the oldest expectation
    always @(posedge aclk) begin : result_check
        exec_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (retire_q.size() == 0) begin
                $error("unexpected result beat");
                n_err++;
            end else begin
                want = retire_q.pop_front();
                check_field("reg_written", 32'(want.reg_written), 32'(m_reg_written));
                check_field("dest_index", 32'(want.dest_index), 32'(m_dest_index));
                check_field("dest_value", want.dest_value, m_dest_value);
                check_field("mem_written", 32'(want.mem_written), 32'(m_mem_written));
                check_field("branch_taken", 32'(want.branch_taken), 32'(m_branch_taken));
                check_field("branch_target", want.branch_target, m_branch_target);
                n_checked++;
            end
        end
    end

    initial begin
        int phase_len [4];
        int tx_pct [4];
        int rx_pct [4];
        int goal;
        phase_len = '{350, 330, 330, 330};
        tx_pct    = '{0, 80, 0, 26};
        rx_pct    = '{0, 0, 80, 26};
        for (int i = 0; i < 32; i++) gpr_shadow[i] = '0;
        for (int i = 0; i < MEM_BYTES; i++) dmem_shadow[i] = '0;

        // Directed instructions, starting from the cleared state
        add_row(OP_LW,    5'd0, 5'd3,  16'h0000, 32'h0, 1'b1,
                '{1'b1, 5'd3, 32'h0, 1'b0, 1'b0, 32'h0});
        add_row(OP_LUI,   5'd0, 5'd1,  16'hFFFF, 32'h0, 1'b1,
                '{1'b1, 5'd1, 32'hFFFF_0000, 1'b0, 1'b0, 32'h0});
        add_row(OP_ADDI,  5'd0, 5'd2,  16'h8000, 32'h0, 1'b1,
                '{1'b1, 5'd2, 32'hFFFF_8000, 1'b0, 1'b0, 32'h0});
        add_row(OP_BEQ,   5'd0, 5'd0,  16'h0000, 32'hFFFF_FFFC, 1'b1,
                '{1'b0, 5'd0, 32'h0, 1'b0, 1'b1, 32'h0});
        add_row(OP_ADDIU, 5'd1, 5'd4,  16'hFFFF, 32'h0, 1'b0, '0);
        add_row(OP_ORI,   5'd1, 5'd5,  16'hFFFF, 32'h0, 1'b0, '0);
        add_row(OP_ANDI,  5'd5, 5'd6,  16'h8000, 32'h0, 1'b0, '0);
        add_row(OP_XORI,  5'd5, 5'd7,  16'hFFFF, 32'h0, 1'b0, '0);
        add_row(OP_ADDI,  5'd5, 5'd17, 16'h0001, 32'h0, 1'b0, '0);
        add_row(OP_SLTI,  5'd1, 5'd8,  16'h0001, 32'h0, 1'b0, '0);
        add_row(OP_SLTIU, 5'd0, 5'd9,  16'h8000, 32'h0, 1'b0, '0);
        add_row(OP_SLTIU, 5'd5, 5'd10, 16'hFFFF, 32'h0, 1'b0, '0);
        add_row(OP_BNE,   5'd1, 5'd0,  16'h8000, 32'h0, 1'b0, '0);
        add_row(OP_BEQ,   5'd1, 5'd5,  16'h7FFF, 32'h1234_5678, 1'b0, '0);
        add_row(OP_SW,    5'd0, 5'd5,  16'hFFFE, 32'h0, 1'b0, '0);
        add_row(OP_LW,    5'd0, 5'd11, 16'hFFFE, 32'h0, 1'b0, '0);
        add_row(OP_SH,    5'd0, 5'd2,  16'h0101, 32'h0, 1'b0, '0);
        add_row(OP_LH,    5'd0, 5'd12, 16'h0101, 32'h0, 1'b0, '0);
        add_row(OP_LHU,   5'd0, 5'd13, 16'h0101, 32'h0, 1'b0, '0);
        add_row(OP_SB,    5'd0, 5'd5,  16'h0FFF, 32'h0, 1'b0, '0);
        add_row(OP_LB,    5'd0, 5'd14, 16'h0FFF, 32'h0, 1'b0, '0);
        add_row(OP_LBU,   5'd0, 5'd15, 16'h0FFF, 32'h0, 1'b0, '0);
        add_row(OP_ADDI,  5'd0, 5'd0,  16'h7FFF, 32'h0, 1'b0, '0);
        add_row(OP_ADDIU, 5'd0, 5'd16, 16'h0001, 32'h0, 1'b0, '0);
        add_row(5'd18,    5'd31, 5'd31, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '0);
        add_row(5'd31,    5'd0, 5'd0,  16'h0000, 32'h0, 1'b1, '0);

        // Hold reset, then release
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            send_beat(dir_tab[i].mode, dir_tab[i].iw, dir_tab[i].pc,
                      dir_tab[i].typed, dir_tab[i].res);
        end
        drain_results();

        // Random traffic under four pressure profiles
        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = tx_pct[p];
            rx_stall_pct = rx_pct[p];
            goal = n_sent + phase_len[p];
            while (n_sent < goal) send_random();
            drain_results();
        end

        repeat (20) @(posedge aclk);
        $display("%0d instructions executed, %0d results checked, %0d branches taken,",
                 n_sent, n_checked, n_taken);
        $display("across sender idling, receiver backpressure and dependent load/store pairs");
        if (n_err == 0) begin
            $display("mips_itype_execute_unit_tb: PASS");
        end else begin
            $display("mips_itype_execute_unit_tb: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("mips_itype_execute_unit_tb: FAIL");
        $finish;
    end

endmodule
